/* hw/rtl/tsgd_pkg.sv */
// Shared constants and code types for the touch swipe gesture detector.
`default_nettype none

package tsgd_pkg;

  // Largest step backward, against the swipe direction, between two samples.
  localparam int BACKUP_LIMIT = 10;

  // The half span of the area is kept modulo 2^16.
  localparam int HALF_BITS = 16;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DETECT_ENABLE = 3'd0,
    REG_AREA_LEFT     = 3'd1,
    REG_AREA_TOP      = 3'd2,
    REG_AREA_RIGHT    = 3'd3,
    REG_AREA_BOTTOM   = 3'd4,
    REG_GESTURE_MODE  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_TAP   = 3'd0,
    MODE_DOWN  = 3'd1,
    MODE_UP    = 3'd2,
    MODE_RIGHT = 3'd3,
    MODE_LEFT  = 3'd4
  } gesture_mode_t;

endpackage

`default_nettype wire

/* hw/rtl/tsgd_intf.sv */
// Valid/ready channel interfaces for touch samples and gesture results.
`default_nettype none

interface tsgd_touch_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  touched;
  logic [COORD_BITS-1:0] touch_x;
  logic [COORD_BITS-1:0] touch_y;

  modport source (output valid, output touched, output touch_x, output touch_y,
                  input ready);
  modport sink (input valid, input touched, input touch_x, input touch_y,
                output ready);
endinterface

interface tsgd_result_if;
  logic valid;
  logic ready;
  logic gesture_seen;

  modport source (output valid, output gesture_seen, input ready);
  modport sink (input valid, input gesture_seen, output ready);
endinterface

`default_nettype wire

/* hw/rtl/touch_swipe_gesture_detector_core.sv */
// Touch swipe gesture detector: one touch sample in, one gesture flag out.
//
// Channels: touch samples (touched, touch_x, touch_y) arrive on a valid/ready
// sink; for every sample exactly one item with gesture_seen leaves on the
// result source, in order. Registers are set through cfg_write, cfg_index and
// cfg_data, only while no sample is in flight: the user's duty, not enforced.
// Path: a sample lands in the input register when accepted, is judged there
// against the stored swipe state and its flag moves into the result register
// once that register is free or being taken, and is offered from there.
// Throughput is one sample per cycle while the receiver keeps ready high;
// the single judge stage between the two registers sets that figure.
// Stall: while the receiver holds ready low, a full result register holds,
// the input register holds behind it, and touch.ready drops once both are
// full. A new sample is still taken while a finished result waits, as long as
// the input register is free.
// Reset: rst (synchronous) clears the valid flags and the configuration
// registers (detection off, tap mode, empty area) and sets the stored swipe
// state to zero.
`default_nettype none

module touch_swipe_gesture_detector_core #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  tsgd_touch_if.sink                                 touch,
  tsgd_result_if.source                              result,
  input  wire logic                                  cfg_write,
  input  wire logic [tsgd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [COORD_BITS-1:0]                 cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int SW = ((CB > tsgd_pkg::HALF_BITS) ? CB : tsgd_pkg::HALF_BITS) + 2;
  localparam logic signed [SW-1:0] LIM_S = SW'(tsgd_pkg::BACKUP_LIMIT);

  // Configuration registers.
  logic          detect_enable;
  logic [CB-1:0] area_left;
  logic [CB-1:0] area_top;
  logic [CB-1:0] area_right;
  logic [CB-1:0] area_bottom;
  logic [2:0]    gesture_mode;

  // Swipe state.
  logic          last_touched;
  logic [CB-1:0] last_x;
  logic [CB-1:0] last_y;
  logic [CB-1:0] start_x;
  logic [CB-1:0] start_y;
  logic          last_touched_next;
  logic [CB-1:0] last_x_next;
  logic [CB-1:0] last_y_next;
  logic [CB-1:0] start_x_next;
  logic [CB-1:0] start_y_next;

  // Input register and result register.
  logic          s1_valid;
  logic          s1_touched;
  logic [CB-1:0] s1_x;
  logic [CB-1:0] s1_y;
  logic          out_valid;
  logic          out_seen;

  logic advance;
  logic fire;

  assign advance      = !out_valid || result.ready;
  assign fire         = s1_valid && advance;
  assign touch.ready  = !s1_valid || advance;
  assign result.valid = out_valid;
  assign result.gesture_seen = out_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_enable <= 1'b0;
      area_left     <= '0;
      area_top      <= '0;
      area_right    <= '0;
      area_bottom   <= '0;
      gesture_mode  <= tsgd_pkg::MODE_TAP;
    end else if (cfg_write) begin
      unique case (tsgd_pkg::cfg_reg_t'(cfg_index))
        tsgd_pkg::REG_DETECT_ENABLE: detect_enable <= cfg_data[0];
        tsgd_pkg::REG_AREA_LEFT:     area_left     <= cfg_data;
        tsgd_pkg::REG_AREA_TOP:      area_top      <= cfg_data;
        tsgd_pkg::REG_AREA_RIGHT:    area_right    <= cfg_data;
        tsgd_pkg::REG_AREA_BOTTOM:   area_bottom   <= cfg_data;
        tsgd_pkg::REG_GESTURE_MODE:  gesture_mode  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Judge logic for the sample in the input register.
  logic          mode_tap;
  logic          mode_swipe;
  logic          vert;
  logic          fwd;
  logic [CB-1:0] lo;
  logic [CB-1:0] hi;
  logic [CB-1:0] qlo;
  logic [CB-1:0] qhi;
  logic [CB-1:0] p;
  logic [CB-1:0] q;
  logic [CB-1:0] lastp;
  logic [CB-1:0] startp;
  logic [CB-1:0] mark;

  logic signed [CB:0]   span;
  logic signed [CB:0]   span_adj;
  logic signed [CB:0]   half;
  logic signed [SW-1:0] half_ext;
  logic [tsgd_pkg::HALF_BITS-1:0] dt;

  logic signed [SW-1:0] s_p;
  logic signed [SW-1:0] s_lo;
  logic signed [SW-1:0] s_hi;
  logic signed [SW-1:0] s_lastp;
  logic signed [SW-1:0] s_start;
  logic signed [SW-1:0] s_dt;

  logic tap_seen;
  logic band_fail;
  logic axis_fail;
  logic axis_done;
  logic swipe_reset;
  logic swipe_seen;
  logic s1_seen;

  always_comb begin
    mode_tap   = (gesture_mode == tsgd_pkg::MODE_TAP);
    mode_swipe = (gesture_mode == tsgd_pkg::MODE_DOWN) || (gesture_mode == tsgd_pkg::MODE_UP) ||
                 (gesture_mode == tsgd_pkg::MODE_RIGHT) || (gesture_mode == tsgd_pkg::MODE_LEFT);
    vert = (gesture_mode == tsgd_pkg::MODE_DOWN) || (gesture_mode == tsgd_pkg::MODE_UP);
    fwd  = (gesture_mode == tsgd_pkg::MODE_DOWN) || (gesture_mode == tsgd_pkg::MODE_RIGHT);

    lo     = vert ? area_top    : area_left;
    hi     = vert ? area_bottom : area_right;
    qlo    = vert ? area_left   : area_top;
    qhi    = vert ? area_right  : area_bottom;
    p      = vert ? s1_y : s1_x;
    q      = vert ? s1_x : s1_y;
    lastp  = vert ? last_y  : last_x;
    startp = vert ? start_y : start_x;
    mark   = fwd ? lo : hi;

    // Half span, truncated toward zero and then wrapped into 16 bits.
    span     = $signed({1'b0, hi}) - $signed({1'b0, lo});
    span_adj = span + $signed({{CB{1'b0}}, span[CB]});
    half     = span_adj >>> 1;
    half_ext = SW'(half);
    dt       = half_ext[tsgd_pkg::HALF_BITS-1:0];

    s_p     = $signed(SW'(p));
    s_lo    = $signed(SW'(lo));
    s_hi    = $signed(SW'(hi));
    s_lastp = $signed(SW'(lastp));
    s_start = $signed(SW'(startp));
    s_dt    = $signed(SW'(dt));

    tap_seen = s1_touched && (s1_x > area_left) && (s1_x < area_right) &&
               (s1_y > area_top) && (s1_y < area_bottom);

    band_fail = (q < qlo) || (q > qhi);
    if (fwd) begin
      axis_fail = (p < lo) || (s_p < s_lastp - LIM_S);
      axis_done = (p >= hi) && last_touched && (lastp <= hi) && (startp > lo) &&
                  (s_start <= s_lo + s_dt);
    end else begin
      axis_fail = (p > hi) || (s_p > s_lastp + LIM_S);
      axis_done = (p <= lo) && last_touched && (lastp >= lo) && (startp < hi) &&
                  (s_start >= s_hi - s_dt);
    end

    swipe_reset = !s1_touched || band_fail || axis_fail || axis_done;
    swipe_seen  = s1_touched && !band_fail && !axis_fail && axis_done;

    s1_seen = detect_enable && ((mode_tap && tap_seen) || (mode_swipe && swipe_seen));
  end

  // Next swipe state; only the swipe axis returns to its unset mark on reset.
  always_comb begin
    last_touched_next = last_touched;
    last_x_next       = last_x;
    last_y_next       = last_y;
    start_x_next      = start_x;
    start_y_next      = start_y;
    if (fire && detect_enable && mode_swipe) begin
      if (!swipe_reset) begin
        last_touched_next = 1'b1;
        last_x_next       = s1_x;
        last_y_next       = s1_y;
        if (startp == mark) begin
          if (vert) begin
            start_y_next = p;
          end else begin
            start_x_next = p;
          end
        end
      end else begin
        last_touched_next = 1'b0;
        if (vert) begin
          last_y_next  = mark;
          start_y_next = mark;
        end else begin
          last_x_next  = mark;
          start_x_next = mark;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      last_touched <= 1'b0;
      last_x       <= '0;
      last_y       <= '0;
      start_x      <= '0;
      start_y      <= '0;
    end else begin
      last_touched <= last_touched_next;
      last_x       <= last_x_next;
      last_y       <= last_y_next;
      start_x      <= start_x_next;
      start_y      <= start_y_next;
      if (touch.valid && touch.ready) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (touch.valid && touch.ready) begin
      s1_touched <= touch.touched;
      s1_x       <= touch.touch_x;
      s1_y       <= touch.touch_y;
    end
    if (fire) begin
      out_seen <= s1_seen;
    end
  end

`ifndef SYNTH
  // The input side only stalls when both registers are occupied.
  assert property (@(posedge clk) disable iff (rst)
    !touch.ready |-> (s1_valid && out_valid && !result.ready))
    else $error("input stalled while a register was free");

  // A completed swipe always leaves the state waiting for a new touch.
  assert property (@(posedge clk) disable iff (rst)
    (fire && mode_swipe && s1_seen) |=> !last_touched)
    else $error("swipe state not reset after a completed swipe");

  // With detection off, a sample neither flags a gesture nor moves the state.
  assert property (@(posedge clk) disable iff (rst)
    (fire && !detect_enable) |=> (!out_seen && $stable(last_touched) &&
      $stable(last_x) && $stable(last_y) && $stable(start_x) && $stable(start_y)))
    else $error("disabled detector changed its answer or state");

  // A gesture is only ever flagged on a touched sample.
  assert property (@(posedge clk) disable iff (rst)
    (fire && s1_seen) |-> s1_touched)
    else $error("gesture flagged on a sample without contact");
`endif

endmodule

`default_nettype wire

/* bench/gesture_flag_checker.sv */
// Checker that predicts the gesture flag of every accepted touch sample and compares results.
`timescale 1ns / 100ps

module gesture_flag_checker #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  tsgd_touch_if                               touch,
  tsgd_result_if                              result,
  input  logic                                cfg_write,
  input  logic [tsgd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  output int                                  mismatches,
  output int                                  flags_pending
);
  import tsgd_pkg::*;

  typedef enum int {
    SWIPE_ONGOING,
    SWIPE_BROKEN,
    SWIPE_COMPLETE
  } swipe_verdict_t;

  logic                  enabled;
  logic [COORD_BITS-1:0] left_edge, top_edge, right_edge, bottom_edge;
  logic [2:0]            mode;

  logic                  prev_touched;
  logic [COORD_BITS-1:0] prev_x, prev_y, origin_x, origin_y;

  logic                  expected_flags[$];

  initial begin
    mismatches    = 0;
    flags_pending = 0;
  end

  function automatic swipe_verdict_t judge_sample(bit forward, int p, int q, int lo, int hi,
                                                  int qlo, int qhi, int lastp, int start);
    int diff;
    int half;
    // The half span is a signed, truncating divide that is then kept to 16 bits.
    diff = (hi - lo) / 2;
    half = diff & 'hFFFF;
    if (q < qlo || q > qhi) return SWIPE_BROKEN;
    if (forward) begin
      if (p < lo || p < lastp - BACKUP_LIMIT) return SWIPE_BROKEN;
      if (p >= hi && prev_touched && lastp <= hi && start > lo && start <= lo + half)
        return SWIPE_COMPLETE;
    end else begin
      if (p > hi || p > lastp + BACKUP_LIMIT) return SWIPE_BROKEN;
      if (p <= lo && prev_touched && lastp >= lo && start < hi && start >= hi - half)
        return SWIPE_COMPLETE;
    end
    return SWIPE_ONGOING;
  endfunction

  // Works out the flag of one sample and advances the stored swipe state.
  function automatic logic predict_flag(logic t, logic [COORD_BITS-1:0] x,
                                        logic [COORD_BITS-1:0] y);
    bit             vert;
    bit             forward;
    int             lo, hi, mark, p, lastp, start;
    swipe_verdict_t verdict;
    if (!enabled) return 1'b0;
    if (mode == MODE_TAP)
      return t && x > left_edge && x < right_edge && y > top_edge && y < bottom_edge;
    if (mode > MODE_LEFT) return 1'b0;
    vert    = (mode == MODE_DOWN) || (mode == MODE_UP);
    forward = (mode == MODE_DOWN) || (mode == MODE_RIGHT);
    lo      = vert ? top_edge : left_edge;
    hi      = vert ? bottom_edge : right_edge;
    mark    = forward ? lo : hi;
    p       = vert ? y : x;
    lastp   = vert ? prev_y : prev_x;
    start   = vert ? origin_y : origin_x;
    if (!t)
      verdict = SWIPE_BROKEN;
    else if (vert)
      verdict = judge_sample(forward, p, x, lo, hi, left_edge, right_edge, lastp, start);
    else
      verdict = judge_sample(forward, p, y, lo, hi, top_edge, bottom_edge, lastp, start);
    if (verdict == SWIPE_ONGOING) begin
      if (start == mark) begin
        if (vert) origin_y = y;
        else origin_x = x;
      end
      prev_touched = 1'b1;
      prev_x       = x;
      prev_y       = y;
    end else begin
      // Only the swipe axis goes back to the unset mark; the cross coordinate stays.
      prev_touched = 1'b0;
      if (vert) begin
        prev_y   = COORD_BITS'(mark);
        origin_y = COORD_BITS'(mark);
      end else begin
        prev_x   = COORD_BITS'(mark);
        origin_x = COORD_BITS'(mark);
      end
    end
    return verdict == SWIPE_COMPLETE;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      enabled      = 1'b0;
      left_edge    = '0;
      top_edge     = '0;
      right_edge   = '0;
      bottom_edge  = '0;
      mode         = MODE_TAP;
      prev_touched = 1'b0;
      prev_x       = '0;
      prev_y       = '0;
      origin_x     = '0;
      origin_y     = '0;
      expected_flags.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DETECT_ENABLE: enabled     = cfg_data[0];
          REG_AREA_LEFT:     left_edge   = cfg_data;
          REG_AREA_TOP:      top_edge    = cfg_data;
          REG_AREA_RIGHT:    right_edge  = cfg_data;
          REG_AREA_BOTTOM:   bottom_edge = cfg_data;
          REG_GESTURE_MODE:  mode        = cfg_data[2:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_flags.size() == 0) begin
          $display("%0t: gesture flag %b arrived with no sample waiting, expected none",
                   $time, result.gesture_seen);
          mismatches++;
        end else begin
          want = expected_flags.pop_front();
          if (result.gesture_seen !== want) begin
            $display("%0t: gesture flag mismatch: expected %b, actual %b",
                     $time, want, result.gesture_seen);
            mismatches++;
          end
        end
      end
      if (touch.valid && touch.ready)
        expected_flags.push_back(predict_flag(touch.touched, touch.touch_x, touch.touch_y));
    end
    flags_pending = expected_flags.size();
  end

endmodule

/* bench/touch_swipe_gesture_detector_core_test.sv */
// Testbench top: touch sample stimulus, result stalls and register setup for the gesture detector.
`timescale 1ns / 100ps

module touch_swipe_gesture_detector_core_test;
  import tsgd_pkg::*;

  localparam int COORD_BITS     = 12;
  localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
  localparam int TARGET_SAMPLES = 1350;

  localparam logic [2:0] MODE_SPARE_LO = MODE_LEFT + 1;
  localparam logic [2:0] MODE_SPARE_HI = '1;

  typedef enum int {
    FLAW_NONE,
    FLAW_FAR_START,
    FLAW_BACKUP,
    FLAW_OFF_BAND,
    FLAW_LIFT
  } swipe_flaw_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0]     cfg_data;
  int                        fail_count;
  int                        flags_pending;

  int                        samples_sent;
  bit                        steady;
  int                        area_l, area_t, area_r, area_b;
  logic [2:0]                mode_now;

  tsgd_touch_if #(.COORD_BITS(COORD_BITS)) touch ();
  tsgd_result_if result ();

  touch_swipe_gesture_detector_core #(.COORD_BITS(COORD_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .touch     (touch),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gesture_flag_checker #(.COORD_BITS(COORD_BITS)) flag_check (
    .clk           (clk),
    .rst           (rst),
    .touch         (touch),
    .result        (result),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (fail_count),
    .flags_pending (flags_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int pause_length(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COORD_BITS-1:0] to_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return COORD_BITS'(v);
  endfunction

  // The receiver alternates ready runs with stalls; one run in ten is a long stall-free stretch.
  initial begin
    int run;
    int stall;
    result.ready <= 1'b0;
    @(negedge clk);
    forever begin
      result.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) @(negedge clk);
      stall = pause_length(1'b0);
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_sample(input logic t, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y);
    int gap;
    gap = pause_length(steady);
    if (gap > 0) begin
      touch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    touch.valid   <= 1'b1;
    touch.touched <= t;
    touch.touch_x <= x;
    touch.touch_y <= y;
    @(posedge clk);
    while (!touch.ready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic send_noise();
    send_sample(1'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  task automatic send_axis(input bit vert, input int p, input int q, input logic t);
    if (vert) send_sample(t, to_coord(q), to_coord(p));
    else send_sample(t, to_coord(p), to_coord(q));
  endtask

  function automatic int cross_pick(int qlo, int qhi, bit outside);
    if (qlo > qhi) return $urandom_range(0, COORD_MAX);
    if (!outside) return $urandom_range(qlo, qhi);
    if (qlo > 0 && (qhi == COORD_MAX || $urandom_range(0, 1))) return $urandom_range(0, qlo - 1);
    if (qhi < COORD_MAX) return $urandom_range(qhi + 1, COORD_MAX);
    return $urandom_range(0, COORD_MAX);
  endfunction

  task automatic write_reg(input cfg_reg_t which, input logic [COORD_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // Unused upper bits of the enable and mode words carry random values.
  task automatic apply_setup(input bit en, input int l, input int t, input int r, input int b,
                             input logic [2:0] m);
    write_reg(REG_DETECT_ENABLE, {(COORD_BITS - 1)'($urandom), en});
    write_reg(REG_AREA_LEFT, COORD_BITS'(l));
    write_reg(REG_AREA_TOP, COORD_BITS'(t));
    write_reg(REG_AREA_RIGHT, COORD_BITS'(r));
    write_reg(REG_AREA_BOTTOM, COORD_BITS'(b));
    write_reg(REG_GESTURE_MODE, {(COORD_BITS - 3)'($urandom), m});
    cfg_write <= 1'b0;
    area_l   = l;
    area_t   = t;
    area_r   = r;
    area_b   = b;
    mode_now = m;
  endtask

  // Drops valid, waits until every flag is back and then lets the pipeline settle.
  task automatic finish_phase();
    touch.valid <= 1'b0;
    while (flags_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // A swipe walks from the near half toward the far edge; a flawed one breaks a rule on the way.
  task automatic send_swipe(input bit spoil);
    bit          vert;
    bit          forward;
    int          lo, hi, qlo, qhi, span, k, step, n;
    swipe_flaw_t flaw;
    vert    = (mode_now == MODE_DOWN) || (mode_now == MODE_UP);
    forward = (mode_now == MODE_DOWN) || (mode_now == MODE_RIGHT);
    lo      = vert ? area_t : area_l;
    hi      = vert ? area_b : area_r;
    qlo     = vert ? area_l : area_t;
    qhi     = vert ? area_r : area_b;
    span    = (hi > lo) ? hi - lo : 0;
    flaw    = spoil ? swipe_flaw_t'($urandom_range(FLAW_FAR_START, FLAW_LIFT)) : FLAW_NONE;
    if ($urandom_range(0, 9) < 7) send_axis(vert, lo, cross_pick(qlo, qhi, 1'b0), 1'b0);
    if (flaw == FLAW_FAR_START && span >= 1)
      k = $urandom_range(span / 2 + 1, span);
    else if ($urandom_range(0, 7) == 0)
      k = 0;
    else
      k = $urandom_range(1, (span > 1) ? span / 2 : 1);
    n = 0;
    while (1) begin
      send_axis(vert, forward ? lo + k : hi - k,
                cross_pick(qlo, qhi, flaw == FLAW_OFF_BAND && n == 2),
                !(flaw == FLAW_LIFT && n == 2));
      if (k >= span || n >= 40) break;
      if (flaw == FLAW_BACKUP && n == 1)
        step = 0 - int'($urandom_range(BACKUP_LIMIT + 1, 40));
      else if ($urandom_range(0, 5) == 0)
        step = ($urandom_range(0, 2) == 0) ? -BACKUP_LIMIT : 0 - int'($urandom_range(1, 10));
      else
        step = $urandom_range(1, (span > 2) ? span / 3 : 1);
      k = (k + step < 0) ? 0 : k + step;
      n++;
    end
  endtask

  task automatic directed_checks();
    // Disabled: the flag is low and the swipe state is left alone.
    apply_setup(1'b0, 100, 100, 400, 400, MODE_DOWN);
    send_sample(1'b1, 250, 150);
    finish_phase();
    // Tap strictly inside, on an edge, without contact, and at the coordinate extremes.
    apply_setup(1'b1, 100, 100, 400, 400, MODE_TAP);
    send_sample(1'b1, 250, 250);
    send_sample(1'b1, 100, 250);
    send_sample(1'b0, 250, 250);
    send_sample(1'b1, 0, 0);
    send_sample(1'b1, COORD_MAX, COORD_MAX);
    finish_phase();
    // Down: a back-up of exactly the limit is tolerated; then a far-half start, a larger
    // back-up and a sample outside the cross band.
    apply_setup(1'b1, 100, 100, 400, 400, MODE_DOWN);
    send_sample(1'b1, 250, 150);
    send_sample(1'b1, 250, 260);
    send_sample(1'b1, 250, 250);
    send_sample(1'b1, 250, 400);
    send_sample(1'b1, 250, 300);
    send_sample(1'b1, 250, 400);
    send_sample(1'b1, 250, 200);
    send_sample(1'b1, 50, 200);
    finish_phase();
    apply_setup(1'b1, 100, 100, 400, 400, MODE_UP);
    send_sample(1'b1, 250, 350);
    send_sample(1'b1, 250, 200);
    send_sample(1'b1, 250, 100);
    finish_phase();
    apply_setup(1'b1, 100, 100, 400, 400, MODE_RIGHT);
    send_sample(1'b1, 150, 250);
    send_sample(1'b1, 300, 250);
    send_sample(1'b1, 400, 250);
    finish_phase();
    apply_setup(1'b1, 100, 100, 400, 400, MODE_LEFT);
    send_sample(1'b1, 350, 250);
    send_sample(1'b1, 200, 250);
    send_sample(1'b1, 100, 250);
    finish_phase();
    apply_setup(1'b1, 100, 100, 400, 400, MODE_SPARE_LO);
    send_sample(1'b1, 250, 250);
    finish_phase();
    // Near the zero edge the back-up bound goes negative and must compare signed.
    apply_setup(1'b1, 0, 0, 40, 40, MODE_RIGHT);
    send_sample(1'b1, 5, 20);
    send_sample(1'b1, 3, 20);
    send_sample(1'b1, 40, 20);
    finish_phase();
  endtask

  task automatic random_phase();
    int         l, t, r, b, shape, count, first, roll;
    bit         en;
    logic [2:0] m;
    shape = $urandom_range(0, 19);
    if (shape < 3) begin
      l = 0;
      t = 0;
      r = COORD_MAX;
      b = COORD_MAX;
    end else if (shape < 5) begin
      l = $urandom_range(0, COORD_MAX - 3);
      r = l + $urandom_range(0, 3);
      t = $urandom_range(0, COORD_MAX - 3);
      b = t + $urandom_range(0, 3);
    end else if (shape == 5) begin
      // Edges given the wrong way round.
      l = $urandom_range(100, COORD_MAX);
      r = $urandom_range(0, l - 1);
      t = $urandom_range(100, COORD_MAX);
      b = $urandom_range(0, t - 1);
    end else if (shape < 8) begin
      if ($urandom_range(0, 1)) begin
        l = 0;
        t = 0;
        r = $urandom_range(20, 600);
        b = $urandom_range(20, 600);
      end else begin
        l = $urandom_range(3500, COORD_MAX - 20);
        t = $urandom_range(3500, COORD_MAX - 20);
        r = COORD_MAX;
        b = COORD_MAX;
      end
    end else begin
      l = $urandom_range(0, 3000);
      r = $urandom_range(l, COORD_MAX);
      t = $urandom_range(0, 3000);
      b = $urandom_range(t, COORD_MAX);
    end
    en   = $urandom_range(0, 9) != 0;
    roll = $urandom_range(0, 19);
    if (roll < 3) m = MODE_TAP;
    else if (roll < 18) m = 3'($urandom_range(MODE_DOWN, MODE_LEFT));
    else m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    steady = $urandom_range(0, 3) == 0;
    apply_setup(en, l, t, r, b, m);
    count = $urandom_range(30, 90);
    first = samples_sent;
    while (samples_sent - first < count) begin
      roll = $urandom_range(0, 99);
      if (mode_now == MODE_TAP || mode_now > MODE_LEFT) begin
        if (roll < 50)
          send_sample($urandom_range(0, 4) != 0, to_coord($urandom_range(area_l, area_r)),
                      to_coord($urandom_range(area_t, area_b)));
        else
          send_noise();
      end else if (roll < 70) begin
        send_swipe(1'b0);
      end else if (roll < 90) begin
        send_swipe(1'b1);
      end else begin
        send_noise();
      end
    end
    finish_phase();
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= REG_DETECT_ENABLE;
    cfg_data      <= '0;
    touch.valid   <= 1'b0;
    touch.touched <= 1'b0;
    touch.touch_x <= '0;
    touch.touch_y <= '0;
    samples_sent  = 0;
    steady        = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_checks();
    while (samples_sent < TARGET_SAMPLES) random_phase();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tsgd_pkg.sv
hw/rtl/tsgd_intf.sv
hw/rtl/touch_swipe_gesture_detector_core.sv
bench/gesture_flag_checker.sv
bench/touch_swipe_gesture_detector_core_test.sv
